### sv/rech_pkg.sv
// ----------------------------------------------------------------------------
// rech_pkg
// Shared types and constants of the random excursion cycle histogram unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rech_pkg;

    // walk bound and counter width
    localparam int unsigned MAX_BITS    = 1048576;
    localparam int unsigned WALK_W      = $clog2(MAX_BITS) + 2;
    localparam int unsigned COUNT_WIDTH = 16;
    localparam int unsigned CNT_W       = 16;

    // counters saturate at 2^COUNT_WIDTH-1, never above the field width
    localparam logic [CNT_W-1:0] COUNT_MAX =
        (COUNT_WIDTH >= CNT_W) ? {CNT_W{1'b1}} : CNT_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    // histogram geometry
    localparam int unsigned N_STATES  = 8;
    localparam int unsigned N_BINS    = 6;
    localparam int unsigned N_ENTRIES = N_STATES * N_BINS;
    localparam logic [2:0]  VISIT_SAT = 3'd5;
    localparam logic [2:0]  LAST_STATE = 3'(N_STATES - 1);
    localparam logic [2:0]  LAST_BIN   = 3'(N_BINS - 1);

    // register indexes
    localparam logic REG_CYCLE_LIMIT = 1'b0;
    localparam logic REG_MIN_CYCLES  = 1'b1;

    // reset values of the configuration registers
    localparam logic [CNT_W-1:0] CYCLE_LIMIT_RST = 16'd10485;
    localparam logic [CNT_W-1:0] MIN_CYCLES_RST  = 16'd500;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_FEW  = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef logic [N_ENTRIES-1:0][CNT_W-1:0] t_hist;
    typedef logic [N_STATES-1:0][2:0]        t_visit;

    typedef struct packed {
        logic [CNT_W-1:0] cycle_limit;
        logic [CNT_W-1:0] min_cycles;
    } t_cfg;

    // snapshot handed from the counting core to the readout buffer
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] total;
        t_status          status;
    } t_snap;

    // readout buffer status seen by the input side
    typedef struct packed {
        logic busy;
        logic free_now;
    } t_rd_stat;

endpackage

`default_nettype wire

### sv/rech_core.sv
// ----------------------------------------------------------------------------
// rech_core
// Random walk, per-cycle visit counters, histogram counters, cycle total and
// overflow flag. One bit is consumed per enabled cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module rech_core
    import rech_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_go,
    input  wire logic  i_bit,
    input  wire logic  i_last,
    input  wire t_cfg  i_cfg,
    output t_snap      o_snap,
    output t_hist      o_hist
);

    localparam logic signed [WALK_W-1:0] WALK_MAX = WALK_W'(MAX_BITS);
    localparam logic signed [WALK_W-1:0] WALK_MIN = -WALK_W'(MAX_BITS);
    localparam logic signed [WALK_W-1:0] NEAR_LO  = -WALK_W'(4);
    localparam logic signed [WALK_W-1:0] NEAR_HI  = WALK_W'(4);

    logic signed [WALK_W-1:0] r_walk, n_walk;
    t_visit                   r_visit, n_visit;
    t_hist                    r_hist, n_hist;
    logic [CNT_W-1:0]         r_total, n_total;
    logic                     r_ovf, n_ovf;

    logic signed [WALK_W-1:0] walk_upd;
    logic                     walk_zero;
    logic                     walk_near;
    logic [2:0]               hit_idx;
    t_visit                   visit_upd;
    logic                     close_cyc;
    logic                     set_ovf;
    logic                     ovf_upd;
    logic [CNT_W-1:0]         total_upd;
    t_hist                    hist_upd;

    // walk step with saturation and visit hit
    always_comb begin
        walk_upd = r_walk;
        if (i_bit) begin
            if (r_walk != WALK_MAX) walk_upd = r_walk + WALK_W'(1);
        end else begin
            if (r_walk != WALK_MIN) walk_upd = r_walk - WALK_W'(1);
        end
        walk_zero = (walk_upd == '0);
        walk_near = (walk_upd >= NEAR_LO) && (walk_upd <= NEAR_HI) && !walk_zero;
        hit_idx   = walk_upd[2:0] + (walk_upd[WALK_W-1] ? 3'd4 : 3'd3);
    end

    // visit counters after this step
    always_comb begin
        for (int s = 0; s < N_STATES; s++) begin
            if (walk_near && hit_idx == 3'(s) && r_visit[s] != VISIT_SAT)
                visit_upd[s] = r_visit[s] + 3'd1;
            else
                visit_upd[s] = r_visit[s];
        end
    end

    // cycle close: zero return within the limit, or open cycle on the last bit
    always_comb begin
        set_ovf   = !r_ovf && walk_zero && (r_total >= i_cfg.cycle_limit);
        close_cyc = !r_ovf && ((walk_zero && (r_total < i_cfg.cycle_limit))
                               || (i_last && !walk_zero));
        ovf_upd   = r_ovf || set_ovf;
        total_upd = (close_cyc && r_total != COUNT_MAX) ? r_total + CNT_W'(1) : r_total;
    end

    // histogram counter cells
    always_comb begin
        for (int s = 0; s < N_STATES; s++) begin
            for (int k = 0; k < N_BINS; k++) begin
                if (close_cyc && visit_upd[s] == 3'(k)
                        && r_hist[s*N_BINS+k] != COUNT_MAX)
                    hist_upd[s*N_BINS+k] = r_hist[s*N_BINS+k] + CNT_W'(1);
                else
                    hist_upd[s*N_BINS+k] = r_hist[s*N_BINS+k];
            end
        end
    end

    // next state: last bit clears everything after the snapshot
    always_comb begin
        n_walk  = r_walk;
        n_visit = r_visit;
        n_hist  = r_hist;
        n_total = r_total;
        n_ovf   = r_ovf;
        if (i_go) begin
            if (i_last) begin
                n_walk  = '0;
                n_visit = '0;
                n_hist  = '0;
                n_total = '0;
                n_ovf   = 1'b0;
            end else begin
                n_walk  = walk_upd;
                n_visit = walk_zero ? '0 : visit_upd;
                n_hist  = hist_upd;
                n_total = total_upd;
                n_ovf   = ovf_upd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_walk  <= '0;
            r_visit <= '0;
            r_hist  <= '0;
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_walk  <= n_walk;
            r_visit <= n_visit;
            r_hist  <= n_hist;
            r_total <= n_total;
            r_ovf   <= n_ovf;
        end
    end

    // snapshot for readout
    always_comb begin
        o_snap.load  = i_go && i_last;
        o_snap.total = total_upd;
        if (ovf_upd)
            o_snap.status = ST_OVERFLOW;
        else if (total_upd < i_cfg.min_cycles)
            o_snap.status = ST_TOO_FEW;
        else
            o_snap.status = ST_OK;
        o_hist = hist_upd;
    end

endmodule

`default_nettype wire

### sv/rech_readout.sv
// ----------------------------------------------------------------------------
// rech_readout
// Holds a histogram snapshot and shifts it out one word per accepted
// output handshake, state index major, visit bin minor.
// ----------------------------------------------------------------------------
`default_nettype none

module rech_readout
    import rech_pkg::*;
(
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_snap         i_snap,
    input  wire t_hist         i_hist,
    input  wire logic          i_stall,
    output logic               o_valid,
    output logic [2:0]         o_state_index,
    output logic [2:0]         o_visit_bin,
    output logic [CNT_W-1:0]   o_bin_cycles,
    output logic [CNT_W-1:0]   o_total_cycles,
    output logic [1:0]         o_status,
    output logic               o_last_result,
    output t_rd_stat           o_rd_stat
);

    t_hist            r_buf, n_buf;
    logic             r_busy, n_busy;
    logic [2:0]       r_state, n_state;
    logic [2:0]       r_bin, n_bin;
    logic [CNT_W-1:0] r_total, n_total;
    t_status          r_status, n_status;

    logic take;
    logic last_word;

    assign take      = r_busy && !i_stall;
    assign last_word = (r_state == LAST_STATE) && (r_bin == LAST_BIN);

    // load a snapshot or advance the shift line
    always_comb begin
        n_buf    = r_buf;
        n_busy   = r_busy;
        n_state  = r_state;
        n_bin    = r_bin;
        n_total  = r_total;
        n_status = r_status;
        if (i_snap.load) begin
            n_buf    = i_hist;
            n_busy   = 1'b1;
            n_state  = '0;
            n_bin    = '0;
            n_total  = i_snap.total;
            n_status = i_snap.status;
        end else if (take) begin
            for (int i = 0; i < N_ENTRIES - 1; i++)
                n_buf[i] = r_buf[i+1];
            n_buf[N_ENTRIES-1] = '0;
            if (last_word) begin
                n_busy = 1'b0;
            end else if (r_bin == LAST_BIN) begin
                n_bin   = '0;
                n_state = r_state + 3'd1;
            end else begin
                n_bin = r_bin + 3'd1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_state <= '0;
            r_bin   <= '0;
        end else begin
            r_busy  <= n_busy;
            r_state <= n_state;
            r_bin   <= n_bin;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_buf    <= n_buf;
        r_total  <= n_total;
        r_status <= n_status;
    end

    assign o_valid          = r_busy;
    assign o_state_index    = r_state;
    assign o_visit_bin      = r_bin;
    assign o_bin_cycles     = r_buf[0];
    assign o_total_cycles   = r_total;
    assign o_status         = r_status;
    assign o_last_result    = last_word;
    assign o_rd_stat.busy     = r_busy;
    assign o_rd_stat.free_now = take && last_word;

endmodule

`default_nettype wire

### sv/random_excursion_cycle_histogram_unit.sv
// ----------------------------------------------------------------------------
// random_excursion_cycle_histogram_unit
// Counting stage of the random excursions test: random walk, zero-return
// cycles and the 6-by-8 visit histogram, read out after the last bit.
// ----------------------------------------------------------------------------
// One sequence bit is taken per clock cycle unless the input is stalled:
// each bit is registered in the input register and is then folded into the
// walk, the visit counters and the histogram counters in the same cycle. The bit
// marked last also copies the histogram, cycle total and status into a
// readout buffer and clears the counting state, so the next sequence can
// start on the following cycle. The buffer shifts out 48 words, one per
// cycle while the output is not stalled, and the first word appears in the
// cycle after the core takes the last bit. A following last bit waits in the
// input register until the previous readout has delivered its final word.
// ----------------------------------------------------------------------------
`default_nettype none

module random_excursion_cycle_histogram_unit
    import rech_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    // configuration
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_addr,
    input  wire logic [CNT_W-1:0] i_cfg_wdata,
    // bit stream
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_bit_value,
    input  wire logic             i_last_bit,
    // histogram words
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic [2:0]            o_state_index,
    output logic [2:0]            o_visit_bin,
    output logic [CNT_W-1:0]      o_bin_cycles,
    output logic [CNT_W-1:0]      o_total_cycles,
    output logic [1:0]            o_status,
    output logic                  o_last_result
);

    t_cfg     r_cfg, n_cfg;
    logic     r_in_valid, n_in_valid;
    logic     r_in_bit;
    logic     r_in_last;
    logic     in_take;
    logic     core_go;
    t_snap    snap;
    t_hist    hist;
    t_rd_stat rd_stat;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CYCLE_LIMIT: n_cfg.cycle_limit = i_cfg_wdata;
                REG_MIN_CYCLES:  n_cfg.min_cycles  = i_cfg_wdata;
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cycle_limit <= CYCLE_LIMIT_RST;
            r_cfg.min_cycles  <= MIN_CYCLES_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // input register; a last bit waits while the readout buffer is occupied
    assign core_go    = r_in_valid && !(r_in_last && rd_stat.busy && !rd_stat.free_now);
    assign o_in_stall = r_in_valid && !core_go;
    assign in_take    = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take)
            n_in_valid = 1'b1;
        else if (core_go)
            n_in_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_in_valid <= 1'b0;
        else
            r_in_valid <= n_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_bit  <= i_bit_value;
            r_in_last <= i_last_bit;
        end
    end

    // counting core
    rech_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (core_go),
        .i_bit   (r_in_bit),
        .i_last  (r_in_last),
        .i_cfg   (r_cfg),
        .o_snap  (snap),
        .o_hist  (hist)
    );

    // readout buffer
    rech_readout u_readout (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_snap         (snap),
        .i_hist         (hist),
        .i_stall        (i_out_stall),
        .o_valid        (o_out_valid),
        .o_state_index  (o_state_index),
        .o_visit_bin    (o_visit_bin),
        .o_bin_cycles   (o_bin_cycles),
        .o_total_cycles (o_total_cycles),
        .o_status       (o_status),
        .o_last_result  (o_last_result),
        .o_rd_stat      (rd_stat)
    );

`ifndef NO_ASSERTIONS
    // a snapshot never overwrites a readout that still has words to deliver
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        snap.load |-> (!rd_stat.busy || rd_stat.free_now))
        else $error("snapshot loaded over an unfinished readout");

    // readout ends after the final word unless a new snapshot arrives
    a_readout_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_last_result && !snap.load) |=> !o_out_valid)
        else $error("readout continued past the final word");

    // input is only held back while an item waits in the input register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_in_last && o_out_valid))
        else $error("input stalled without a waiting last bit");

    // visit bin stays within the six bins
    a_bin_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_visit_bin <= LAST_BIN))
        else $error("visit bin out of range");
`endif

endmodule

`default_nettype wire
